@@ src/abtu_pkg.sv @@
`default_nettype none
package abtu_pkg;

    localparam int MaxAnchors = 1024;
    localparam int IdxW = $clog2(MaxAnchors);
    localparam int CntW = IdxW + 1;

    localparam int ChipW = 8;
    localparam int ModW = 49;
    localparam int TickW = 9;
    localparam int CfgDataW = 49;
    localparam int CfgIdxW = 3;
    localparam int DivBits = 64;

    localparam logic [CfgIdxW-1:0] REG_CHIP = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PIX_MOD = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_TDC_MOD = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CTL_MOD = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TICK_CRS = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_TICK_TDC = 3'd5;

    localparam logic [1:0] CMD_ANCHOR = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_TDC = 2'd2;
    localparam logic [1:0] CMD_CONTROL = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  item_chip;
        logic [31:0] chunk_pos;
        logic [31:0] packet_pos;
        logic [47:0] raw_value;
        logic [3:0]  fine_toa;
        logic        is_count_packet;
    } abtu_in_t;

    typedef struct packed {
        logic [63:0]        unwrapped_value;
        logic signed [63:0] fine_time;
        logic               assigned;
        logic               unresolved;
        logic               table_full;
    } abtu_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SRCH_RD,
        ST_SRCH_WAIT,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WAIT,
        ST_SHIFT_WR,
        ST_INS_WR,
        ST_HIT_RD,
        ST_HIT_WAIT,
        ST_MUL,
        ST_DIV,
        ST_EPOCH,
        ST_DONE
    } abtu_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture request
        logic srch_init;
        logic srch_rd;     // read at mid
        logic srch_step;   // update lo/hi from compare
        logic shift_init;
        logic shift_rd;    // read entry ptr-1
        logic shift_wr;    // write entry ptr, decrement ptr
        logic ins_wr;      // write new anchor at lo
        logic hit_rd;      // read anchor at lo-1 (or 0)
        logic mul;         // form a and r
        logic mul2;        // epoch*modulus, one 32-bit partial product per cycle
        logic div_init;
        logic div_step;
        logic finish;      // build result
        logic res_full;
        logic res_pass;
        logic res_empty;
    } abtu_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic chip_match;
        logic [1:0] cmd;
        logic count_pkt;
        logic full;
        logic empty;
        logic srch_done;
        logic shift_done;
        logic div_done;
        logic gap_pos;
        logic mul_done;
    } abtu_stat_t;

endpackage
`default_nettype wire

@@ src/abtu_ram.sv @@
`default_nettype none
module abtu_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ src/abtu_ctrl.sv @@
`default_nettype none
module abtu_ctrl
    import abtu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire abtu_stat_t stat,
    output abtu_cmd_t       ctl,
    output logic            busy,
    output logic            done
);
    abtu_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        busy = (state_reg != ST_IDLE);
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                ctl.srch_init = 1'b1;
                priority if (!stat.chip_match)
                begin
                    ctl.res_pass = 1'b1;
                    state_next = ST_DONE;
                end
                else if (stat.cmd == CMD_ANCHOR && stat.full)
                begin
                    ctl.res_full = 1'b1;
                    state_next = ST_DONE;
                end
                else if (stat.cmd == CMD_CONTROL && stat.count_pkt)
                begin
                    ctl.res_pass = 1'b1;
                    state_next = ST_DONE;
                end
                else if (stat.cmd != CMD_ANCHOR && stat.empty)
                begin
                    ctl.res_empty = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD:
            begin
                if (stat.srch_done)
                begin
                    if (stat.cmd == CMD_ANCHOR)
                    begin
                        ctl.shift_init = 1'b1;
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = ST_HIT_RD;
                    end
                end
                else
                begin
                    ctl.srch_rd = 1'b1;
                    state_next = ST_SRCH_WAIT;
                end
            end
            ST_SRCH_WAIT: state_next = ST_SRCH_CMP;
            ST_SRCH_CMP:
            begin
                ctl.srch_step = 1'b1;
                state_next = ST_SRCH_RD;
            end
            ST_SHIFT_RD:
            begin
                if (stat.shift_done)
                begin
                    state_next = ST_INS_WR;
                end
                else
                begin
                    ctl.shift_rd = 1'b1;
                    state_next = ST_SHIFT_WAIT;
                end
            end
            ST_SHIFT_WAIT:
            begin
                // keep the read address so the read data stays on ptr-1
                ctl.shift_rd = 1'b1;
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                ctl.shift_wr = 1'b1;
                state_next = ST_SHIFT_RD;
            end
            ST_INS_WR:
            begin
                ctl.ins_wr = 1'b1;
                ctl.res_pass = 1'b1;
                state_next = ST_DONE;
            end
            ST_HIT_RD:
            begin
                ctl.hit_rd = 1'b1;
                state_next = ST_HIT_WAIT;
            end
            ST_HIT_WAIT:
            begin
                ctl.hit_rd = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                ctl.mul = 1'b1;
                state_next = ST_DIV;
                ctl.div_init = 1'b1;
            end
            ST_DIV:
            begin
                if (stat.div_done || !stat.gap_pos)
                begin
                    state_next = ST_EPOCH;
                end
                else
                begin
                    ctl.div_step = 1'b1;
                end
            end
            ST_EPOCH:
            begin
                ctl.mul2 = 1'b1;
                if (stat.mul_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                ctl.finish = 1'b1;
                done = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ src/abtu_dpath.sv @@
`default_nettype none
module abtu_dpath
    import abtu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire abtu_in_t            req,
    input  wire abtu_cmd_t           ctl,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_idx,
    input  wire logic [CfgDataW-1:0] cfg_data,
    output abtu_stat_t               stat,
    output abtu_out_t                result
);
    logic [ChipW-1:0] chip_sel_reg;
    logic [ModW-1:0]  pix_mod_reg, tdc_mod_reg, ctl_mod_reg;
    logic [TickW-1:0] tick_crs_reg, tick_tdc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_sel_reg <= '0;
            pix_mod_reg  <= ModW'(64'h4000_0000);
            tdc_mod_reg  <= ModW'(64'h8_0000_0000);
            ctl_mod_reg  <= ModW'(64'h1_0000_0000_0000);
            tick_crs_reg <= TickW'(16);
            tick_tdc_reg <= TickW'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_CHIP:     chip_sel_reg <= cfg_data[ChipW-1:0];
                REG_PIX_MOD:  pix_mod_reg <= cfg_data[ModW-1:0];
                REG_TDC_MOD:  tdc_mod_reg <= cfg_data[ModW-1:0];
                REG_CTL_MOD:  ctl_mod_reg <= cfg_data[ModW-1:0];
                REG_TICK_CRS: tick_crs_reg <= cfg_data[TickW-1:0];
                REG_TICK_TDC: tick_tdc_reg <= cfg_data[TickW-1:0];
                default: ;
            endcase
        end
    end

    // anchor count
    logic [CntW-1:0] count_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.ins_wr)
        begin
            count_reg <= count_reg + CntW'(1);
        end
    end

    // captured request
    abtu_in_t rq_reg;
    logic [63:0] key;
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rq_reg <= req;
        end
    end
    assign key = {rq_reg.chunk_pos, rq_reg.packet_pos};

    // table memories
    logic            we;
    logic [IdxW-1:0] waddr, raddr;
    logic [47:0]     wtime, rtime;
    logic [63:0]     wpos, rpos;

    abtu_ram #(.Width(48), .Depth(MaxAnchors)) u_time (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wtime),
        .raddr(raddr), .rdata(rtime)
    );
    abtu_ram #(.Width(64), .Depth(MaxAnchors)) u_pos (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wpos),
        .raddr(raddr), .rdata(rpos)
    );

    // binary search / shift pointers
    logic [CntW-1:0] lo_reg, hi_reg, ptr_reg, mid;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_ff @(posedge clk)
    begin
        if (ctl.srch_init)
        begin
            lo_reg <= '0;
            hi_reg <= count_reg;
        end
        else if (ctl.srch_step)
        begin
            if (key < rpos)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid + CntW'(1);
            end
        end
        if (ctl.shift_init)
        begin
            ptr_reg <= count_reg;
        end
        else if (ctl.shift_wr)
        begin
            ptr_reg <= ptr_reg - CntW'(1);
        end
    end

    logic [CntW-1:0] prev;
    assign prev = (lo_reg == '0) ? '0 : lo_reg - CntW'(1);

    always_comb
    begin
        priority if (ctl.shift_rd)
        begin
            raddr = IdxW'(ptr_reg - CntW'(1));
        end
        else if (ctl.hit_rd)
        begin
            raddr = IdxW'(prev);
        end
        else
        begin
            raddr = IdxW'(mid);
        end
        we = ctl.shift_wr | ctl.ins_wr;
        if (ctl.ins_wr)
        begin
            waddr = IdxW'(lo_reg);
            wtime = rq_reg.raw_value;
            wpos  = key;
        end
        else
        begin
            waddr = IdxW'(ptr_reg);
            wtime = rtime;
            wpos  = rpos;
        end
    end

    // epoch math
    logic [ModW-1:0]  mod_sel;
    logic [TickW-1:0] fac_sel;
    always_comb
    begin
        unique case (rq_reg.cmd)
            CMD_PIXEL:
            begin
                mod_sel = pix_mod_reg;
                fac_sel = tick_crs_reg;
            end
            CMD_TDC:
            begin
                mod_sel = tdc_mod_reg;
                fac_sel = tick_tdc_reg;
            end
            default:
            begin
                mod_sel = ctl_mod_reg;
                fac_sel = tick_crs_reg;
            end
        endcase
    end

    logic [63:0] a_full, r_full, w_full;
    logic [63:0] num_reg, w_reg, quo_reg, rem_reg;
    logic        gap_pos_reg;
    logic [$clog2(DivBits+1)-1:0] dcnt_reg;
    assign a_full = 64'(rtime) * 64'(tick_crs_reg);
    assign r_full = 64'(rq_reg.raw_value) * 64'(fac_sel);
    assign w_full = 64'(mod_sel) * 64'(fac_sel);

    logic [64:0] rem_sh;
    assign rem_sh = {rem_reg, num_reg[63]};

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            gap_pos_reg <= (a_full > r_full) && (w_full != '0);
            num_reg <= a_full - r_full + (w_full >> 1);
            w_reg <= w_full;
            rem_reg <= '0;
            quo_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            // restoring division, one quotient bit per cycle
            num_reg <= num_reg << 1;
            if (rem_sh >= {1'b0, w_reg})
            begin
                rem_reg <= 64'(rem_sh - {1'b0, w_reg});
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + ($clog2(DivBits+1))'(1);
        end
    end

    // epoch*modulus mod 2^64 from three 32x32 partial products, one per cycle:
    // lo*lo, then hi(epoch)*lo(mod) and lo(epoch)*hi(mod) into the upper word
    logic [1:0]  mstep_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    always_comb
    begin
        unique case (mstep_reg)
            2'd0:
            begin
                mul_a = quo_reg[31:0];
                mul_b = mod_sel[31:0];
            end
            2'd1:
            begin
                mul_a = quo_reg[63:32];
                mul_b = mod_sel[31:0];
            end
            default:
            begin
                mul_a = quo_reg[31:0];
                mul_b = 32'(mod_sel[ModW-1:32]);
            end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    logic [63:0] prod_reg;
    always_ff @(posedge clk)
    begin
        if (ctl.div_init || ctl.res_empty)
        begin
            prod_reg <= '0;
            mstep_reg <= '0;
        end
        else if (ctl.mul2)
        begin
            prod_reg <= prod_reg + ((mstep_reg == 2'd0) ? mul_p : {mul_p[31:0], 32'd0});
            mstep_reg <= mstep_reg + 2'd1;
        end
    end

    // result
    logic [63:0] unw;
    assign unw = 64'(rq_reg.raw_value) + prod_reg;

    // result registers are built in the cycle the outcome is known
    abtu_out_t res_next;
    always_comb
    begin
        res_next = '0;
        res_next.unwrapped_value = 64'(rq_reg.raw_value);
        res_next.table_full = ctl.res_full;
        if (ctl.res_empty || ctl.mul2)
        begin
            res_next.assigned = 1'b1;
            res_next.unresolved = ctl.res_empty;
        end
    end

    abtu_out_t hold_reg;
    logic      is_hit_reg;
    always_ff @(posedge clk)
    begin
        if (ctl.res_pass || ctl.res_full || ctl.res_empty || ctl.mul2)
        begin
            hold_reg <= res_next;
            is_hit_reg <= ctl.res_empty || ctl.mul2;
        end
    end

    always_comb
    begin
        result = hold_reg;
        if (is_hit_reg)
        begin
            result.unwrapped_value = unw;
            if (rq_reg.cmd == CMD_PIXEL)
            begin
                result.fine_time = $signed((unw << 4) - 64'(rq_reg.fine_toa));
            end
        end
    end

    assign stat.chip_match = (rq_reg.item_chip == chip_sel_reg);
    assign stat.cmd        = rq_reg.cmd;
    assign stat.count_pkt  = rq_reg.is_count_packet;
    assign stat.full       = (count_reg >= CntW'(MaxAnchors));
    assign stat.empty      = (count_reg == '0);
    assign stat.srch_done  = (lo_reg >= hi_reg);
    assign stat.shift_done = (ptr_reg == lo_reg);
    assign stat.div_done   = (dcnt_reg == ($clog2(DivBits+1))'(DivBits));
    assign stat.gap_pos    = gap_pos_reg;
    assign stat.mul_done   = (mstep_reg == 2'd2);
endmodule
`default_nettype wire

@@ src/anchor_based_timestamp_unwrap_unit.sv @@
`default_nettype none
// Anchor-based timestamp unwrap. Hold start high with a request; it is taken
// at the first rising edge where busy is low, and exactly one result appears
// on result with done high for one cycle, the last cycle that busy is high.
// The receiver cannot stall it. Anchors (cmd 0) go into a sorted 1024-entry
// table: a binary search, each probe a read, a wait and a compare (up to 10
// probes on an insert, 11 on a lookup), then a move of every later entry by
// a read, a wait and a write. Hits run the same search, a table read, a
// 64-step restoring divider and a partial-product multiply; a hit whose
// anchor is not ahead of it, or whose scaled modulus is zero, skips the
// divider. Pass-through, dropped and empty-table items go from decode
// straight to done. The table holds no reset state; only the fill count is
// cleared. Configuration writes are taken any time but are meant only while
// busy is low.
module anchor_based_timestamp_unwrap_unit
    import abtu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire abtu_in_t            request,
    output logic                     busy,
    output logic                     done,
    output abtu_out_t                result,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_idx,
    input  wire logic [CfgDataW-1:0] cfg_data
);
    abtu_cmd_t  ctl;
    abtu_stat_t stat;
    abtu_out_t  res_w;

    abtu_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .stat(stat),
        .ctl(ctl), .busy(busy), .done(done)
    );

    abtu_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .req(request), .ctl(ctl),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .stat(stat), .result(res_w)
    );

    assign result = res_w;
endmodule
`default_nettype wire

@@ src/abtu_checker.sv @@
`default_nettype none
module abtu_checker
    import abtu_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      done,
    input wire abtu_out_t result
);
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("busy after done");
    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done while idle");
    a_unres: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.unresolved) |-> result.assigned)
        else $error("unresolved without assigned");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |-> !result.assigned)
        else $error("dropped anchor marked assigned");
endmodule

bind anchor_based_timestamp_unwrap_unit abtu_checker u_abtu_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .result(result)
);
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import abtu_pkg::*;

    localparam int WatchLimit = 20000;   // longest insert shifts every stored entry
    localparam int DrainCycles = 200;
    localparam int ItemsPerSetting = 28;
    localparam int NumSettings = 8;

    logic clk;
    logic rst_n;
    logic start;
    abtu_in_t request;
    logic busy;
    logic done;
    abtu_out_t result;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_idx;
    logic [CfgDataW-1:0] cfg_data;

    anchor_based_timestamp_unwrap_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the block: configuration and the sorted anchor table
    // ---------------------------------------------------------------
    logic [7:0]  sh_chip;
    logic [63:0] sh_pix_mod;
    logic [63:0] sh_tdc_mod;
    logic [63:0] sh_ctl_mod;
    logic [63:0] sh_tick_crs;
    logic [63:0] sh_tick_tdc;
    logic [47:0] anchor_stamp [MaxAnchors];
    logic [63:0] anchor_key [MaxAnchors];
    int          anchor_fill;

    abtu_out_t pending_unwraps[$];
    bit        failed;
    int        idle_cycles;

    // upper bound: first entry whose key is greater than key
    function automatic int first_later(logic [63:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = anchor_fill;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (key < anchor_key[mid])
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    // Expected result of one request; updates the shadow table on inserts.
    function automatic abtu_out_t predict_unwrap(abtu_in_t q);
        abtu_out_t o;
        logic [63:0] key;
        logic [63:0] modv;
        logic [63:0] fac;
        logic [63:0] a;
        logic [63:0] r;
        logic [63:0] w;
        logic [63:0] epoch;
        logic [63:0] uv;
        int pos;
        key = {q.chunk_pos, q.packet_pos};
        o = '0;
        o.unwrapped_value = {16'd0, q.raw_value};
        epoch = '0;
        if (q.item_chip != sh_chip)
            return o;
        if (q.cmd == CMD_ANCHOR)
        begin
            if (anchor_fill >= MaxAnchors)
            begin
                o.table_full = 1'b1;
                return o;
            end
            pos = first_later(key);
            for (int i = anchor_fill; i > pos; i--)
            begin
                anchor_stamp[i] = anchor_stamp[i-1];
                anchor_key[i] = anchor_key[i-1];
            end
            anchor_stamp[pos] = q.raw_value;
            anchor_key[pos] = key;
            anchor_fill++;
            return o;
        end
        if (q.cmd == CMD_CONTROL && q.is_count_packet)
            return o;
        case (q.cmd)
            CMD_PIXEL: begin modv = sh_pix_mod; fac = sh_tick_crs; end
            CMD_TDC:   begin modv = sh_tdc_mod; fac = sh_tick_tdc; end
            default:   begin modv = sh_ctl_mod; fac = sh_tick_crs; end
        endcase
        if (anchor_fill == 0)
            o.unresolved = 1'b1;
        else
        begin
            pos = first_later(key);
            if (pos > 0)
                pos--;
            a = {16'd0, anchor_stamp[pos]} * sh_tick_crs;
            r = {16'd0, q.raw_value} * fac;
            w = modv * fac;
            if (a > r && w != 0)
                epoch = (a - r + w / 2) / w;
        end
        uv = {16'd0, q.raw_value} + epoch * modv;
        o.unwrapped_value = uv;
        o.assigned = 1'b1;
        if (q.cmd == CMD_PIXEL)
            o.fine_time = (uv << 4) - {60'd0, q.fine_toa};
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Result checker: every done pulse is matched against the oldest entry
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        abtu_out_t want;
        if (done)
        begin
            if (pending_unwraps.size() == 0)
            begin
                $error("result with nothing outstanding: %p", result);
                failed = 1'b1;
            end
            else
            begin
                want = pending_unwraps.pop_front();
                if (result.unwrapped_value !== want.unwrapped_value)
                begin
                    $error("unwrapped_value exp %h got %h",
                           want.unwrapped_value, result.unwrapped_value);
                    failed = 1'b1;
                end
                if (result.fine_time !== want.fine_time)
                begin
                    $error("fine_time exp %h got %h", want.fine_time, result.fine_time);
                    failed = 1'b1;
                end
                if (result.assigned !== want.assigned)
                begin
                    $error("assigned exp %b got %b", want.assigned, result.assigned);
                    failed = 1'b1;
                end
                if (result.unresolved !== want.unresolved)
                begin
                    $error("unresolved exp %b got %b", want.unresolved, result.unresolved);
                    failed = 1'b1;
                end
                if (result.table_full !== want.table_full)
                begin
                    $error("table_full exp %b got %b", want.table_full, result.table_full);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog: cycles with no request taken, no result seen and no configuration write
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    int burst_left;

    // Holds start high until the request is taken. If typed is set, the
    // typed-in result is queued instead of the predicted one.
    task automatic send_request(abtu_in_t q, bit typed, abtu_out_t typed_out);
        abtu_out_t p;
        start <= 1'b1;
        request <= q;
        // busy is sampled before the edge updates the controller
        @(posedge clk iff !busy);
        p = predict_unwrap(q);
        pending_unwraps = {pending_unwraps, (typed ? typed_out : p)};
    endtask

    // Bursty sender: random-length bursts, random gaps between them.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 8);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_unwraps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val[CfgDataW-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CHIP:     sh_chip = val[7:0];
            REG_PIX_MOD:  sh_pix_mod = {15'd0, val[48:0]};
            REG_TDC_MOD:  sh_tdc_mod = {15'd0, val[48:0]};
            REG_CTL_MOD:  sh_ctl_mod = {15'd0, val[48:0]};
            REG_TICK_CRS: sh_tick_crs = {55'd0, val[8:0]};
            REG_TICK_TDC: sh_tick_tdc = {55'd0, val[8:0]};
            default: ;
        endcase
    endtask

    function automatic logic [63:0] pick_modulus(int setting);
        case (setting)
            0: return 64'd1;
            1: return 64'h1_0000_0000_0000;          // 2^48, top bit of the 49-bit field
            2: return 64'd0;                          // zero wrap
            3: return 64'h1_FFFF_FFFF_FFFF;          // all 49 bits set
            default:
                case ($urandom_range(0, 2))
                    0: return 64'($urandom_range(1, 5000));
                    1: return 64'd1 << $urandom_range(8, 48);
                    default: return {$urandom, $urandom} & 64'h1_FFFF_FFFF_FFFF;
                endcase
        endcase
    endfunction

    function automatic logic [63:0] pick_ticks(int setting);
        case (setting)
            0: return 64'd1;
            1: return 64'd256;
            2: return 64'd0;
            3: return 64'd511;
            default: return 64'($urandom_range(1, 256));
        endcase
    endfunction

    // mostly well-formed traffic for the selected chip, keys clustered so
    // hits land between, on and around stored anchors
    function automatic abtu_in_t random_request(bit allow_anchor);
        abtu_in_t q;
        int kind;
        q.cmd = 2'($urandom_range(0, 3));
        kind = $urandom_range(0, 99);
        if (!allow_anchor && q.cmd == CMD_ANCHOR)
            q.cmd = CMD_PIXEL;
        q.item_chip = ($urandom_range(0, 9) < 8) ? sh_chip : 8'($urandom);
        if (kind < 85)
        begin
            q.chunk_pos = $urandom_range(0, 7);
            q.packet_pos = $urandom_range(0, 15);
        end
        else
        begin
            q.chunk_pos = $urandom;
            q.packet_pos = $urandom;
        end
        case ($urandom_range(0, 3))
            0: q.raw_value = 48'($urandom_range(0, 4095));
            1: q.raw_value = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 4095));
            default: q.raw_value = 48'({$urandom, $urandom});
        endcase
        q.fine_toa = 4'($urandom);
        q.is_count_packet = 1'($urandom_range(0, 3) == 0);
        return q;
    endfunction

    typedef struct {
        abtu_in_t  q;
        bit        typed;
        abtu_out_t want;
    } stim_row_t;

    function automatic abtu_in_t mk_req(logic [1:0] c, logic [7:0] chip, logic [31:0] ch,
                                        logic [31:0] pk, logic [47:0] raw,
                                        logic [3:0] ft, logic cp);
        abtu_in_t q;
        q.cmd = c;
        q.item_chip = chip;
        q.chunk_pos = ch;
        q.packet_pos = pk;
        q.raw_value = raw;
        q.fine_toa = ft;
        q.is_count_packet = cp;
        return q;
    endfunction

    function automatic abtu_out_t mk_res(logic [63:0] uv, logic [63:0] ft,
                                         logic asg, logic unr);
        abtu_out_t o;
        o.unwrapped_value = uv;
        o.fine_time = ft;
        o.assigned = asg;
        o.unresolved = unr;
        o.table_full = 1'b0;
        return o;
    endfunction

    stim_row_t directed[$];
    abtu_in_t  nq;
    abtu_out_t none;

    function automatic void add_row(stim_row_t row);
        directed = {directed, row};
    endfunction

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        failed = 1'b0;
        idle_cycles = 0;
        burst_left = 0;
        none = '0;
        // reset values of the configuration
        sh_chip = 8'd0;
        sh_pix_mod = 64'd1 << 30;
        sh_tdc_mod = 64'd1 << 35;
        sh_ctl_mod = 64'd1 << 48;
        sh_tick_crs = 64'd16;
        sh_tick_tdc = 64'd2;
        anchor_fill = 0;

        // empty table: epoch 0, unresolved, fine time still formed
        add_row('{mk_req(CMD_PIXEL, 8'd0, 32'd3, 32'd1, 48'h123, 4'd5, 1'b0), 1,
                  mk_res(64'h123, 64'h1230 - 64'd5, 1'b1, 1'b1)});
        add_row('{mk_req(CMD_TDC, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         48'hFFFF_FFFF_FFFF, 4'd15, 1'b1), 1,
                  mk_res(64'hFFFF_FFFF_FFFF, 64'd0, 1'b1, 1'b1)});
        add_row('{mk_req(CMD_CONTROL, 8'd0, 32'd0, 32'd0, 48'd0, 4'd0, 1'b0), 1,
                  mk_res(64'd0, 64'd0, 1'b1, 1'b1)});
        // count packet and foreign-chip hit pass through
        add_row('{mk_req(CMD_CONTROL, 8'd0, 32'd0, 32'd0, 48'd7, 4'd0, 1'b1), 1,
                  mk_res(64'd7, 64'd0, 1'b0, 1'b0)});
        add_row('{mk_req(CMD_PIXEL, 8'd255, 32'd0, 32'd0, 48'd9, 4'd15, 1'b0), 1,
                  mk_res(64'd9, 64'd0, 1'b0, 1'b0)});
        // inserts, one from a foreign chip, one with an equal key
        add_row('{mk_req(CMD_ANCHOR, 8'd0, 32'd1, 32'd0, 48'h4000_0000, 4'd0, 1'b0),
                  1, mk_res(64'h4000_0000, 64'd0, 1'b0, 1'b0)});
        add_row('{mk_req(CMD_ANCHOR, 8'd255, 32'd0, 32'd0, 48'h55, 4'd0, 1'b0), 1,
                  mk_res(64'h55, 64'd0, 1'b0, 1'b0)});
        add_row('{mk_req(CMD_ANCHOR, 8'd0, 32'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 4'd0,
                         1'b0), 1, mk_res(64'hFFFF_FFFF_FFFF, 64'd0, 1'b0, 1'b0)});
        add_row('{mk_req(CMD_ANCHOR, 8'd0, 32'd1, 32'd0, 48'h3, 4'd0, 1'b0), 1,
                  mk_res(64'h3, 64'd0, 1'b0, 1'b0)});
        add_row('{mk_req(CMD_ANCHOR, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd0,
                         4'd0, 1'b0), 1, mk_res(64'd0, 64'd0, 1'b0, 1'b0)});
        // lookups against the table: predicted
        add_row('{mk_req(CMD_PIXEL, 8'd0, 32'd0, 32'd0, 48'd0, 4'd15, 1'b0), 0, none});
        add_row('{mk_req(CMD_PIXEL, 8'd0, 32'd0, 32'd5, 48'h10, 4'd1, 1'b0), 0, none});
        add_row('{mk_req(CMD_TDC, 8'd0, 32'd1, 32'd0, 48'h1, 4'd0, 1'b0), 0, none});
        add_row('{mk_req(CMD_CONTROL, 8'd0, 32'd1, 32'd7, 48'h2, 4'd0, 1'b0), 0, none});
        add_row('{mk_req(CMD_PIXEL, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         48'hFFFF_FFFF_FFFF, 4'd8, 1'b0), 0, none});
        add_row('{mk_req(CMD_TDC, 8'd0, 32'd0, 32'd0, 48'h123_4567, 4'd0, 1'b1),
                  0, none});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_request(directed[i].q, directed[i].typed, directed[i].want);
            pace_sender();
        end

        // configuration settings, extremes first, then random traffic in each
        for (int s = 0; s < NumSettings; s++)
        begin
            wait_idle();
            write_reg(REG_CHIP, (s == 1) ? 64'd255
                                         : (s < 4 ? 64'd0 : 64'($urandom_range(0, 255))));
            write_reg(REG_PIX_MOD, pick_modulus(s));
            write_reg(REG_TDC_MOD, pick_modulus((s + 1) % NumSettings));
            write_reg(REG_CTL_MOD, pick_modulus((s + 3) % NumSettings));
            write_reg(REG_TICK_CRS, pick_ticks(s));
            write_reg(REG_TICK_TDC, pick_ticks((s + 2) % NumSettings));
            // indexes past the register list must be ignored
            write_reg(CfgIdxW'(6 + (s % 2)), {$urandom, $urandom});
            @(posedge clk);
            for (int i = 0; i < ItemsPerSetting; i++)
            begin
                send_request(random_request(anchor_fill < 300), 1'b0, none);
                pace_sender();
            end
        end

        // fill the table with ascending keys (only larger stored keys shift), then overflow it
        wait_idle();
        write_reg(REG_CHIP, 64'd42);
        write_reg(REG_TICK_CRS, 64'd16);
        write_reg(REG_PIX_MOD, 64'd1 << 30);
        @(posedge clk);
        for (int i = 0; anchor_fill < MaxAnchors; i++)
        begin
            nq = mk_req(CMD_ANCHOR, 8'd42, 32'hFFFF_0000 + i, 32'($urandom),
                        48'({$urandom, $urandom}), 4'($urandom), 1'b0);
            send_request(nq, 1'b0, none);
            pace_sender();
        end
        for (int i = 0; i < 40; i++)
        begin
            // drops interleaved with lookups into the full table
            nq = random_request(1'b1);
            if (i % 2 == 0)
            begin
                nq.cmd = CMD_ANCHOR;
                nq.item_chip = 8'd42;
            end
            send_request(nq, 1'b0, none);
            pace_sender();
        end

        start <= 1'b0;
        while (pending_unwraps.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (!failed && pending_unwraps.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
